>>> sv/tpi_pkg.sv
// ----------------------------------------------------------------------------
// tpi_pkg
// Shared constants for the tracked position interpolator: field widths,
// register indexes and register reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tpi_pkg;

    localparam int TIME_BITS      = 32;  // modular microsecond timestamp
    localparam int INTERVAL_BITS  = 20;  // width of the interval bound registers
    localparam int CFG_ADDR_BITS  = 2;
    localparam int COORD_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int IN_USER_BITS   = 2;   // has_sample, sample_ok
    localparam int OUT_USER_BITS  = 2;   // out_valid, blended

    localparam logic [CFG_ADDR_BITS-1:0] REG_INTERP_ENABLE = 2'd0;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MIN_INTERVAL  = 2'd1;
    localparam logic [CFG_ADDR_BITS-1:0] REG_MAX_INTERVAL  = 2'd2;

    localparam logic                     RST_INTERP_ENABLE = 1'b1;
    localparam logic [INTERVAL_BITS-1:0] RST_MIN_INTERVAL  = 20'd400;
    localparam logic [INTERVAL_BITS-1:0] RST_MAX_INTERVAL  = 20'd33333;

endpackage : tpi_pkg

`default_nettype wire

>>> sv/tpi_div.sv
// ----------------------------------------------------------------------------
// tpi_div
// Restoring divider, one quotient bit a cycle. Gives
// floor(num * 2^FRAC_BITS / den) for num < den.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpi_div #(
    parameter int FRAC_BITS = tpi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    input  wire logic [tpi_pkg::TIME_BITS-1:0]  num,
    input  wire logic [tpi_pkg::TIME_BITS-1:0]  den,
    output logic                                done,
    output logic [FRAC_BITS-1:0]                quo
);
    import tpi_pkg::*;

    localparam int CNT_W = $clog2(FRAC_BITS + 1);

    logic [TIME_BITS-1:0] rem_reg, rem_next;
    logic [TIME_BITS-1:0] den_reg;
    logic [FRAC_BITS-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [TIME_BITS:0]   shifted;
    logic                 fits;

    // remainder stays below den, so the doubled value fits in one extra bit
    always_comb
    begin
        shifted   = {rem_reg, 1'b0};
        fits      = (shifted >= {1'b0, den_reg});
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            quo_next  = '0;
            cnt_next  = CNT_W'(FRAC_BITS);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? TIME_BITS'(shifted - {1'b0, den_reg})
                            : shifted[TIME_BITS-1:0];
            quo_next = {quo_reg[FRAC_BITS-2:0], fits};
            cnt_next = cnt_reg - CNT_W'(1);
            if (cnt_reg == CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        if (start)
        begin
            den_reg <= den;
        end
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule : tpi_div

`default_nettype wire

>>> sv/tpi_lane.sv
// ----------------------------------------------------------------------------
// tpi_lane
// One axis of the blend: prior + sign(d) * round(|d| * t / 2^FRAC_BITS),
// d = last - prior. The product is built from two half-width partials.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpi_lane #(
    parameter int COORD_BITS = tpi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tpi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [FRAC_BITS:0]           t,
    input  wire logic signed [COORD_BITS-1:0] prior,
    input  wire logic signed [COORD_BITS-1:0] last,
    output logic                              done,
    output logic signed [COORD_BITS-1:0]      result
);
    import tpi_pkg::*;

    localparam int DW   = COORD_BITS + 1;
    localparam int LO_W = (DW + 1) / 2;
    localparam int HI_W = DW - LO_W;
    localparam int TW   = FRAC_BITS + 1;
    localparam int SW   = DW + TW;

    logic [3:0]                stage_reg, stage_next;
    logic                      done_reg;
    logic signed [DW-1:0]      diff;
    logic [DW-1:0]             mag_reg;
    logic                      neg_reg;
    logic signed [DW-1:0]      prior_reg;
    logic [TW-1:0]             t_reg;
    logic [LO_W+TW-1:0]        plo_reg;
    logic [HI_W+TW-1:0]        phi_reg;
    logic [SW-1:0]             sum_reg;
    logic [DW-1:0]             step;
    logic signed [DW-1:0]      res_wide;
    logic signed [COORD_BITS-1:0] res_reg;

    assign diff       = DW'(last) - DW'(prior);
    assign stage_next = {stage_reg[2:0], start};
    assign step       = sum_reg[FRAC_BITS +: DW];
    assign res_wide   = neg_reg ? (prior_reg - signed'(step)) : (prior_reg + signed'(step));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            stage_reg <= stage_next;
            done_reg  <= stage_reg[3];
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            neg_reg   <= diff[DW-1];
            mag_reg   <= diff[DW-1] ? DW'(-diff) : DW'(diff);
            prior_reg <= DW'(prior);
            t_reg     <= t;
        end
        if (stage_reg[0])
        begin
            plo_reg <= mag_reg[LO_W-1:0] * t_reg;
        end
        if (stage_reg[1])
        begin
            phi_reg <= mag_reg[DW-1:LO_W] * t_reg;
        end
        if (stage_reg[2])
        begin
            // rounding: add half a result lsb before dropping the fraction
            sum_reg <= SW'({phi_reg, {LO_W{1'b0}}}) + SW'(plo_reg)
                       + (SW'(1) << (FRAC_BITS - 1));
        end
        if (stage_reg[3])
        begin
            res_reg <= res_wide[COORD_BITS-1:0];
        end
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule : tpi_lane

`default_nettype wire

>>> sv/tracked_position_interpolator.sv
// ----------------------------------------------------------------------------
// tracked_position_interpolator
// Tracker update in, interpolated 3-axis position out. Keeps the last two
// sample positions and times and blends between them by elapsed time.
// ----------------------------------------------------------------------------
//
//  Channel  Dir  Handshake                tdata (low to high)       tuser
//  s_axis   in   tvalid/tready            time_us, pos_x/y/z        has_sample, sample_ok
//  m_axis   out  tvalid/tready            out_x, out_y, out_z       out_valid, blended
//  cfg      in   cfg_we (no back-press.)  cfg_addr, cfg_data        -
//
// Flow: a taken word is evaluated, then, when a blend factor has to be
//   divided out, the bit-serial divider forms t; the three axis lanes then
//   form their two partial products, rounding and sum. Each word runs to
//   the output register before the next is taken.
// Reset: rst_n clears all control state, the sample history and the
//   registers to their defaults; no clearing pass is needed.
// Stalls: a finished word sits in the output register while the next update
//   is taken; the block only holds s_axis_tready low while working on one or
//   while its finished word waits for the output register to free up.
//
`timescale 1ns / 1ps
`default_nettype none

module tracked_position_interpolator #(
    parameter int COORD_BITS = tpi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tpi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    // slave side
    input  wire logic                                         s_axis_tvalid,
    output logic                                              s_axis_tready,
    // time_us, pos_x, pos_y, pos_z, zero pad
    input  wire logic [((tpi_pkg::TIME_BITS+3*COORD_BITS+7)/8)*8-1:0] s_axis_tdata,
    // has_sample, sample_ok
    input  wire logic [tpi_pkg::IN_USER_BITS-1:0]             s_axis_tuser,
    // master side
    output logic                                              m_axis_tvalid,
    input  wire logic                                         m_axis_tready,
    // out_x, out_y, out_z, zero pad
    output logic [((3*COORD_BITS+7)/8)*8-1:0]                 m_axis_tdata,
    // out_valid, blended
    output logic [tpi_pkg::OUT_USER_BITS-1:0]                 m_axis_tuser,
    // configuration
    input  wire logic                                         cfg_we,
    input  wire logic [tpi_pkg::CFG_ADDR_BITS-1:0]            cfg_addr,
    input  wire logic [tpi_pkg::INTERVAL_BITS-1:0]            cfg_data
);
    import tpi_pkg::*;

    localparam int OUT_W  = ((3*COORD_BITS + 7) / 8) * 8;
    localparam int NLANES = 3;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_EVAL = 5'b00010,
        S_DIV  = 5'b00100,
        S_LANE = 5'b01000,
        S_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;

    // configuration
    logic                     interp_en_reg;
    logic [INTERVAL_BITS-1:0] min_int_reg;
    logic [INTERVAL_BITS-1:0] max_int_reg;

    // sample history
    logic                  seen_reg;
    logic [TIME_BITS-1:0]  now_time_reg;
    logic [TIME_BITS-1:0]  last_time_reg;
    logic [TIME_BITS-1:0]  prior_time_reg;
    logic signed [COORD_BITS-1:0] last_pos_reg  [NLANES];
    logic signed [COORD_BITS-1:0] prior_pos_reg [NLANES];

    logic                  in_acc;
    logic                  has_sample;
    logic                  sample_ok;
    logic [TIME_BITS-1:0]  time_us;

    // evaluation
    logic [TIME_BITS-1:0]  interval;
    logic [TIME_BITS-1:0]  elapsed;
    logic                  do_blend;
    logic                  need_div;
    logic                  blend_reg;

    logic                  div_start;
    logic                  div_done;
    logic [FRAC_BITS-1:0]  div_quo;

    logic                  lane_start;
    logic [FRAC_BITS:0]    lane_t;
    logic [NLANES-1:0]     lane_done;
    logic signed [COORD_BITS-1:0] lane_res [NLANES];

    // output register
    logic                  out_load;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]      m_data_reg;
    logic [OUT_USER_BITS-1:0] m_user_reg;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign time_us       = s_axis_tdata[TIME_BITS-1:0];
    assign has_sample    = s_axis_tuser[0];
    assign sample_ok     = s_axis_tuser[1];

    // ---- configuration registers ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interp_en_reg <= RST_INTERP_ENABLE;
            min_int_reg   <= RST_MIN_INTERVAL;
            max_int_reg   <= RST_MAX_INTERVAL;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                REG_INTERP_ENABLE: interp_en_reg <= cfg_data[0];
                REG_MIN_INTERVAL:  min_int_reg   <= cfg_data;
                REG_MAX_INTERVAL:  max_int_reg   <= cfg_data;
                default:           ;  // unmapped index, write dropped
            endcase
        end
    end

    // ---- sample history, updated as the word is taken ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg       <= 1'b0;
            now_time_reg   <= '0;
            last_time_reg  <= '0;
            prior_time_reg <= '0;
            for (int i = 0; i < NLANES; i++)
            begin
                last_pos_reg[i]  <= '0;
                prior_pos_reg[i] <= '0;
            end
        end
        else if (in_acc)
        begin
            now_time_reg <= time_us;
            if (has_sample)
            begin
                // first sample: prior time equals the sample time
                prior_time_reg <= seen_reg ? last_time_reg : time_us;
                last_time_reg  <= time_us;
                seen_reg       <= 1'b1;
                if (sample_ok)
                begin
                    for (int i = 0; i < NLANES; i++)
                    begin
                        prior_pos_reg[i] <= last_pos_reg[i];
                        last_pos_reg[i]  <= s_axis_tdata[TIME_BITS + i*COORD_BITS +: COORD_BITS];
                    end
                end
            end
        end
    end

    // ---- interval check; intervals wrap modulo 2^32 ----
    assign interval = last_time_reg - prior_time_reg;
    assign elapsed  = now_time_reg - last_time_reg;
    assign do_blend = interp_en_reg
                      && (interval >= TIME_BITS'(min_int_reg))
                      && (interval <= TIME_BITS'(max_int_reg));
    assign need_div = do_blend && (elapsed < interval);

    assign div_start  = (state_reg == S_EVAL) && need_div;
    assign lane_start = ((state_reg == S_EVAL) && !need_div)
                        || ((state_reg == S_DIV) && div_done);
    // t is one whenever no division is needed; with t one a lane returns last
    assign lane_t     = (state_reg == S_DIV) ? {1'b0, div_quo}
                                             : ((FRAC_BITS+1)'(1) << FRAC_BITS);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EVAL)
        begin
            blend_reg <= do_blend;
        end
    end

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: if (in_acc) state_next = S_EVAL;
            S_EVAL: state_next = need_div ? S_DIV : S_LANE;
            S_DIV:  if (div_done) state_next = S_LANE;
            S_LANE: if (&lane_done) state_next = S_OUT;
            S_OUT:  if (out_load) state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    tpi_div #(
        .FRAC_BITS (FRAC_BITS)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (elapsed),
        .den   (interval),
        .done  (div_done),
        .quo   (div_quo)
    );

    // one lane per axis, all started together
    for (genvar g = 0; g < NLANES; g++)
    begin : g_lane
        tpi_lane #(
            .COORD_BITS (COORD_BITS),
            .FRAC_BITS  (FRAC_BITS)
        ) u_lane (
            .clk    (clk),
            .rst_n  (rst_n),
            .start  (lane_start),
            .t      (lane_t),
            .prior  (prior_pos_reg[g]),
            .last   (last_pos_reg[g]),
            .done   (lane_done[g]),
            .result (lane_res[g])
        );
    end

    // ---- merge lanes into the output register ----
    // before any sample the whole word reads zero
    assign out_load     = (state_reg == S_OUT) && (!m_valid_reg || m_axis_tready);
    assign m_valid_next = out_load ? 1'b1 : (m_axis_tready ? 1'b0 : m_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else
        begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            if (seen_reg)
            begin
                m_data_reg <= OUT_W'({lane_res[2], lane_res[1], lane_res[0]});
                m_user_reg <= {blend_reg, 1'b1};
            end
            else
            begin
                m_data_reg <= '0;
                m_user_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;

endmodule : tracked_position_interpolator

`default_nettype wire

>>> sv/tpi_check.sv
// ----------------------------------------------------------------------------
// tpi_check
// Port-level checks for the tracked position interpolator, bound to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tpi_check #(
    parameter int COORD_BITS = tpi_pkg::COORD_BITS_DEF,
    parameter int FRAC_BITS  = tpi_pkg::FRAC_BITS_DEF
) (
    input  wire logic                                         clk,
    input  wire logic                                         rst_n,
    input  wire logic                                         s_axis_tvalid,
    input  wire logic                                         s_axis_tready,
    input  wire logic                                         m_axis_tvalid,
    input  wire logic                                         m_axis_tready,
    input  wire logic [((3*COORD_BITS+7)/8)*8-1:0]            m_axis_tdata,
    input  wire logic [tpi_pkg::OUT_USER_BITS-1:0]            m_axis_tuser
);
    import tpi_pkg::*;

    // stalled word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid
            && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("output word changed under stall");

    // one word in flight: input closes right after a take
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second word taken while one is in work");

    // blended implies a sample has been seen
    a_blend_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser[1] |-> m_axis_tuser[0])
        else $error("blended flag without valid position");

    // no sample yet: position reads zero
    a_zero_before_sample: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> (m_axis_tdata == '0))
        else $error("position non-zero before any sample");

    // no result can appear sooner than the shortest path through the lanes
    a_min_latency: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && !m_axis_tvalid |=> ##2 !$rose(m_axis_tvalid))
        else $error("result appeared too early");

endmodule : tpi_check

bind tracked_position_interpolator tpi_check #(
    .COORD_BITS (COORD_BITS),
    .FRAC_BITS  (FRAC_BITS)
) u_tpi_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

>>> verif/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the tracked position interpolator. A directed list
// covers reset output, extreme positions, interval bounds, non-finite samples,
// backward time steps and register masking. Random tracker sequences follow
// under several register settings. Each output word is compared with its
// hand-worked value or an in-bench model of the sample history and blend arithmetic.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import tpi_pkg::*;

    localparam int COORD  = COORD_BITS_DEF;
    localparam int FRAC   = FRAC_BITS_DEF;
    localparam int IN_W   = ((TIME_BITS + 3 * COORD + 7) / 8) * 8;
    localparam int OUT_W  = ((3 * COORD + 7) / 8) * 8;

    localparam longint T_ONE    = longint'(1) << FRAC;   // blend factor of one
    localparam longint HALF_LSB = T_ONE >> 1;            // round half away from zero

    localparam int IDLE_PCT      = 17;      // idle cycles per hundred, each side
    localparam int HOLD_CYCLES   = 300;     // long receiver hold-off
    localparam int PHASE_WORDS   = 64;      // random words per register setting
    localparam int N_PHASES      = 6;
    localparam int TAIL_CYCLES   = 60;      // quiet tail, longer than the worst word latency
    localparam int CYCLE_LIMIT   = 400000;

    // index 3 is not a register; writes there must be dropped
    localparam logic [CFG_ADDR_BITS-1:0] REG_SPARE = 2'd3;

    localparam logic signed [31:0] P_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] P_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] M_ONE = -32'sd1;

    // one tracker update as offered on s_axis
    typedef struct packed {
        logic [31:0]        time_us;
        logic               has_sample;
        logic               sample_ok;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } update_t;

    // one position word as seen on m_axis
    typedef struct packed {
        logic               out_valid;
        logic               blended;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } pos_word_t;

    typedef enum logic { ROW_WORD, ROW_REG } row_kind_t;

    typedef struct packed {
        row_kind_t                  kind;
        logic [CFG_ADDR_BITS-1:0]   reg_idx;
        logic [INTERVAL_BITS-1:0]   reg_val;
        update_t                    upd;
        logic                       typed;   // want holds a hand-worked result
        pos_word_t                  want;
    } row_t;

    typedef struct packed {
        logic                       en;
        logic [INTERVAL_BITS-1:0]   lo;
        logic [INTERVAL_BITS-1:0]   hi;
    } reg_set_t;

    localparam update_t   NO_UPD  = '0;
    localparam pos_word_t NO_WANT = '0;

    // ------------------------------------------------------------------------
    // DUT signals
    // ------------------------------------------------------------------------
    logic                       clk;
    logic                       rst_n;
    logic                       s_axis_tvalid;
    logic                       s_axis_tready;
    logic [IN_W-1:0]            s_axis_tdata;    // time_us, pos_x, pos_y, pos_z
    logic [IN_USER_BITS-1:0]    s_axis_tuser;    // has_sample, sample_ok
    logic                       m_axis_tvalid;
    logic                       m_axis_tready;
    logic [OUT_W-1:0]           m_axis_tdata;    // out_x, out_y, out_z
    logic [OUT_USER_BITS-1:0]   m_axis_tuser;    // out_valid, blended
    logic                       cfg_we;
    logic [CFG_ADDR_BITS-1:0]   cfg_addr;
    logic [INTERVAL_BITS-1:0]   cfg_data;

    tracked_position_interpolator u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // Bench state
    // ------------------------------------------------------------------------
    pos_word_t pending_words [$];   // expected words, oldest first
    int        n_errors    = 0;
    int        cycle_count = 0;
    bit        calm        = 1'b0;  // no idling on either side while set
    bit        hold_req    = 1'b0;  // ask the receiver for its long hold-off

    // register shadow
    logic                       lerp_en = RST_INTERP_ENABLE;
    logic [INTERVAL_BITS-1:0]   lo_us   = RST_MIN_INTERVAL;
    logic [INTERVAL_BITS-1:0]   hi_us   = RST_MAX_INTERVAL;

    // sample history, mirrors the block's own
    bit                 seen_any  = 1'b0;
    logic [31:0]        now_us    = '0;
    logic [31:0]        last_us   = '0;
    logic [31:0]        prior_us  = '0;
    logic signed [31:0] last_xyz  [3] = '{default: '0};
    logic signed [31:0] prior_xyz [3] = '{default: '0};

    // ------------------------------------------------------------------------
    // Position model
    // ------------------------------------------------------------------------

    // prior + sign(d) * round(|d| * frac / 2^FRAC); always lands between the two
    function automatic logic signed [31:0] lerp_axis(input logic signed [31:0] p,
                                                     input logic signed [31:0] l,
                                                     input longint frac);
        longint d;
        longint mag;
        longint step;
        d    = longint'(l) - longint'(p);
        mag  = (d < 0) ? -d : d;
        step = (mag * frac + HALF_LSB) >>> FRAC;
        return (d < 0) ? 32'(longint'(p) - step) : 32'(longint'(p) + step);
    endfunction

    function automatic pos_word_t track_update(input update_t u);
        pos_word_t   r;
        logic [31:0] span;
        logic [31:0] since;
        longint      frac;
        logic        blend_on;
        now_us = u.time_us;
        if (u.has_sample)
        begin
            // first sample: prior time equals sample time, interval zero
            prior_us = seen_any ? last_us : u.time_us;
            if (u.sample_ok)
            begin
                prior_xyz = last_xyz;
                last_xyz  = '{u.x, u.y, u.z};
            end
            last_us  = u.time_us;
            seen_any = 1'b1;
        end
        r = '0;
        if (seen_any)
        begin
            // modular differences, so a backward step reads as a huge interval
            span     = last_us - prior_us;
            since    = now_us - last_us;
            blend_on = lerp_en && span >= lo_us && span <= hi_us;
            frac     = T_ONE;
            if (blend_on && since < span)
                frac = (longint'(since) << FRAC) / longint'(span);
            r.out_valid = 1'b1;
            r.blended   = blend_on;
            r.x = blend_on ? lerp_axis(prior_xyz[0], last_xyz[0], frac) : last_xyz[0];
            r.y = blend_on ? lerp_axis(prior_xyz[1], last_xyz[1], frac) : last_xyz[1];
            r.z = blend_on ? lerp_axis(prior_xyz[2], last_xyz[2], frac) : last_xyz[2];
        end
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Driving
    // ------------------------------------------------------------------------
    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        n_errors++;
        $display("%0t MISMATCH %s: got %h, expected %h", $time, what, got, want);
    endtask

    // Offer one word and wait for it to be taken. tvalid is left high after
    // acceptance so back-to-back words need no second assignment in a step.
    task automatic send_word(input update_t u, input logic typed, input pos_word_t want);
        pos_word_t model_out;
        if (!calm)
            while ($urandom_range(99) < IDLE_PCT)
            begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
            end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {u.z, u.y, u.x, u.time_us};
        s_axis_tuser  <= {u.sample_ok, u.has_sample};
        do
            @(posedge clk);
        while (!s_axis_tready);
        // registers only change while idle, so predicting here is safe
        model_out = track_update(u);
        pending_words.insert(pending_words.size(), typed ? want : model_out);
    endtask

    // Stop offering and wait for every outstanding word. Always waits for a clock
    // edge first, so the caller never reassigns tvalid in the same step.
    task automatic drain_words();
        s_axis_tvalid <= 1'b0;
        do
            @(posedge clk);
        while (pending_words.size() != 0);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_BITS-1:0] idx,
                             input logic [INTERVAL_BITS-1:0] val);
        drain_words();
        @(posedge clk);
        cfg_we   <= 1'b1;
        cfg_addr <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we   <= 1'b0;
        case (idx)
            REG_INTERP_ENABLE: lerp_en = val[0];    // upper bits masked off
            REG_MIN_INTERVAL:  lo_us   = val;
            REG_MAX_INTERVAL:  hi_us   = val;
            default: ;                              // spare index, dropped
        endcase
    endtask

    function automatic logic signed [31:0] rand_coord();
        if ($urandom_range(1))
            return $urandom;
        return $signed($urandom_range(4000)) - 2000;
    endfunction

    // Sample spacing: mostly inside the blend window, with the bounds
    // themselves and some out-of-window spans mixed in.
    function automatic logic [31:0] pick_span();
        logic [31:0] lo;
        logic [31:0] hi;
        lo = lo_us;
        hi = hi_us;
        case ($urandom_range(9))
            0:       return lo;
            1:       return hi;
            2:       return $urandom_range(2 * hi + 100);
            default: return (lo <= hi) ? $urandom_range(hi, lo) : $urandom_range(lo);
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Directed list. Rows with typed = 1 carry a hand-worked word; the rest
    // are checked against the model. Reset settings: blend on, 400..33333 us.
    // ------------------------------------------------------------------------
    localparam int N_PLAN = 29;

    row_t plan [N_PLAN] = '{
        // nothing sampled yet: all zero, and tuser flags without has_sample
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd100, 1'b0, 1'b0, P_MAX, P_MIN, M_ONE},
          1'b1, NO_WANT},
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'hFFFF_FFFF, 1'b0, 1'b1, P_MIN, P_MAX, M_ONE},
          1'b1, NO_WANT},
        // first sample: zero interval, below the window, passed through
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd1000, 1'b1, 1'b1, P_MAX, P_MIN, 32'sd0},
          1'b1, '{1'b1, 1'b0, P_MAX, P_MIN, 32'sd0}},
        // full-scale swing, interval 1000; no time elapsed gives the prior
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd2000, 1'b1, 1'b1, P_MIN, P_MAX, M_ONE},
          1'b1, '{1'b1, 1'b1, P_MAX, P_MIN, 32'sd0}},
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd2500, 1'b0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
          1'b0, NO_WANT},
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd2999, 1'b0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
          1'b0, NO_WANT},
        // elapsed equals interval: t is one
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd3000, 1'b0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
          1'b1, '{1'b1, 1'b1, P_MIN, P_MAX, M_ONE}},
        // non-finite sample: times move, positions kept
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd4000, 1'b1, 1'b0, 32'sd123, 32'sd123, 32'sd123},
          1'b1, '{1'b1, 1'b1, P_MAX, P_MIN, 32'sd0}},
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd4700, 1'b0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
          1'b0, NO_WANT},
        // update time behind the last sample: wraps to a long elapsed time
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd3000, 1'b0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
          1'b1, '{1'b1, 1'b1, P_MIN, P_MAX, M_ONE}},
        // interval 40000 above the window
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd44000, 1'b1, 1'b1, 32'sd1, 32'sd2, 32'sd3},
          1'b1, '{1'b1, 1'b0, 32'sd1, 32'sd2, 32'sd3}},
        // interval 399, one below the window
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd44399, 1'b1, 1'b1, -32'sd4, -32'sd5, -32'sd6},
          1'b1, '{1'b1, 1'b0, -32'sd4, -32'sd5, -32'sd6}},
        // interval exactly on the lower bound
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd44799, 1'b1, 1'b1, 32'sd1000, -32'sd1000, 32'sd7},
          1'b1, '{1'b1, 1'b1, -32'sd4, -32'sd5, -32'sd6}},
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd44999, 1'b0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
          1'b0, NO_WANT},
        // interval exactly on the upper bound
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd78132, 1'b1, 1'b1, -32'sd7, 32'sd9, 32'sd65536},
          1'b1, '{1'b1, 1'b1, 32'sd1000, -32'sd1000, 32'sd7}},
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd90000, 1'b0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
          1'b0, NO_WANT},
        // enable written with upper bits set: only bit 0 counts, so off
        '{ROW_REG, REG_INTERP_ENABLE, 20'hFFFFE, NO_UPD, 1'b0, NO_WANT},
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd90001, 1'b0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
          1'b1, '{1'b1, 1'b0, -32'sd7, 32'sd9, 32'sd65536}},
        // widest window; the spare write would narrow it if it aliased
        '{ROW_REG, REG_INTERP_ENABLE, 20'd1, NO_UPD, 1'b0, NO_WANT},
        '{ROW_REG, REG_MIN_INTERVAL, 20'd0, NO_UPD, 1'b0, NO_WANT},
        '{ROW_REG, REG_MAX_INTERVAL, 20'hFFFFF, NO_UPD, 1'b0, NO_WANT},
        '{ROW_REG, REG_SPARE, 20'd6, NO_UPD, 1'b0, NO_WANT},
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd90001, 1'b1, 1'b1, P_MIN, P_MAX, 32'sd0},
          1'b1, '{1'b1, 1'b1, -32'sd7, 32'sd9, 32'sd65536}},
        // second sample at the same time: zero interval, t is one
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd90001, 1'b1, 1'b1, P_MAX, P_MIN, 32'sd5},
          1'b1, '{1'b1, 1'b1, P_MAX, P_MIN, 32'sd5}},
        // sample earlier than the last: wrapped interval, outside any window
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd100, 1'b1, 1'b1, 32'sd11, 32'sd22, 32'sd33},
          1'b1, '{1'b1, 1'b0, 32'sd11, 32'sd22, 32'sd33}},
        // bounds of 1000000, window of a single value
        '{ROW_REG, REG_MIN_INTERVAL, 20'd1000000, NO_UPD, 1'b0, NO_WANT},
        '{ROW_REG, REG_MAX_INTERVAL, 20'd1000000, NO_UPD, 1'b0, NO_WANT},
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd1000100, 1'b1, 1'b1, 32'sd44, 32'sd55, 32'sd66},
          1'b1, '{1'b1, 1'b1, 32'sd11, 32'sd22, 32'sd33}},
        '{ROW_WORD, REG_SPARE, 20'd0, '{32'd1500100, 1'b0, 1'b0, 32'sd0, 32'sd0, 32'sd0},
          1'b0, NO_WANT}
    };

    // register settings for the random part; extremes included
    reg_set_t phase_plan [N_PHASES] = '{
        '{1'b1, 20'd400,     20'd33333},    // reset values; long receiver hold
        '{1'b1, 20'd0,       20'hFFFFF},    // widest window, no idling
        '{1'b0, 20'd400,     20'd33333},    // pass-through
        '{1'b1, 20'd1000000, 20'd1000000},
        '{1'b1, 20'd0,       20'd0},        // zero interval only
        '{1'b1, 20'd2000,    20'd2500}
    };

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        update_t     u;
        logic [31:0] clock_us;
        logic [31:0] span;
        int          sent;
        bit          paused;

        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        cfg_we        <= 1'b0;
        cfg_addr      <= REG_INTERP_ENABLE;
        cfg_data      <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].reg_idx, plan[i].reg_val);
            else
                send_word(plan[i].upd, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < N_PHASES; p++)
        begin
            write_reg(REG_INTERP_ENABLE, 20'(phase_plan[p].en));
            write_reg(REG_MIN_INTERVAL, phase_plan[p].lo);
            write_reg(REG_MAX_INTERVAL, phase_plan[p].hi);
            calm = (p == 1);
            if (p == 0)
                hold_req = 1'b1;    // receiver stalls while we keep offering
            clock_us = $urandom;    // lets the timestamps wrap now and then
            sent     = 0;
            paused   = 1'b0;
            while (sent < PHASE_WORDS)
            begin
                // halfway through, let the output side empty completely
                if (!paused && sent >= PHASE_WORDS / 2)
                begin
                    drain_words();
                    paused = 1'b1;
                end
                if ($urandom_range(99) < 88)
                begin
                    // a sample, then a few plain updates up to a quarter past its interval
                    span         = pick_span();
                    clock_us     = clock_us + span;
                    u.time_us    = clock_us;
                    u.has_sample = 1'b1;
                    u.sample_ok  = ($urandom_range(9) != 0);
                    u.x          = rand_coord();
                    u.y          = rand_coord();
                    u.z          = rand_coord();
                    send_word(u, 1'b0, NO_WANT);
                    sent++;
                    repeat ($urandom_range(3))
                    begin
                        u.time_us    = clock_us + $urandom_range(span + span / 4);
                        u.has_sample = 1'b0;
                        u.sample_ok  = $urandom_range(1);
                        u.x          = $urandom;
                        u.y          = $urandom;
                        u.z          = $urandom;
                        send_word(u, 1'b0, NO_WANT);
                        sent++;
                    end
                end
                else
                begin
                    // noise: any time, any flags, any position
                    u.time_us    = $urandom;
                    u.has_sample = $urandom_range(1);
                    u.sample_ok  = $urandom_range(1);
                    u.x          = $urandom;
                    u.y          = $urandom;
                    u.z          = $urandom;
                    send_word(u, 1'b0, NO_WANT);
                    sent++;
                end
            end
        end

        drain_words();
        calm = 1'b0;
        repeat (TAIL_CYCLES) @(posedge clk);
        if (n_errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Receiver: random back-pressure plus one long hold-off when asked
    // ------------------------------------------------------------------------
    initial
    begin : receiver
        int held;
        held = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req && held < HOLD_CYCLES)
            begin
                held++;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // ------------------------------------------------------------------------
    // Output check: each accepted word against the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin : word_check
        pos_word_t got;
        pos_word_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = '{m_axis_tuser[0], m_axis_tuser[1], m_axis_tdata[31:0],
                    m_axis_tdata[63:32], m_axis_tdata[95:64]};
            if (pending_words.size() == 0)
                report_mismatch("word with nothing pending, out_x", got.x, 32'd0);
            else
            begin
                want = pending_words.pop_front();
                if (got.out_valid !== want.out_valid)
                    report_mismatch("out_valid", 32'(got.out_valid), 32'(want.out_valid));
                if (got.blended !== want.blended)
                    report_mismatch("blended", 32'(got.blended), 32'(want.blended));
                if (got.x !== want.x)
                    report_mismatch("out_x", got.x, want.x);
                if (got.y !== want.y)
                    report_mismatch("out_y", got.y, want.y);
                if (got.z !== want.z)
                    report_mismatch("out_z", got.z, want.z);
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

endmodule
